[rtl/core/ucint_pkg.sv]
// shared types, codes and helpers for the unwind code interpreter
package ucint_pkg;

  localparam int RESQ_DEPTH    = 4;
  localparam int RESQ_MAX_PUSH = 3;
  localparam int RESQ_PTR_W    = $clog2(RESQ_DEPTH);
  localparam int RESQ_CNT_W    = $clog2(RESQ_DEPTH + 1);

  localparam logic [63:0] RET_ADDR_SIZE = 64'd8;
  localparam logic [63:0] MFRAME_SP_OFS = 64'd24;

  typedef enum logic {
    ITEM_BEGIN = 1'b0,
    ITEM_SLOT  = 1'b1
  } item_op_t;

  typedef enum logic [3:0] {
    UOP_PUSH_NONVOL     = 4'd0,
    UOP_ALLOC_LARGE     = 4'd1,
    UOP_ALLOC_SMALL     = 4'd2,
    UOP_SET_FPREG       = 4'd3,
    UOP_SAVE_NONVOL     = 4'd4,
    UOP_SAVE_NONVOL_FAR = 4'd5,
    UOP_EPILOG          = 4'd6,
    UOP_SPARE           = 4'd7,
    UOP_SAVE_XMM128     = 4'd8,
    UOP_SAVE_XMM128_FAR = 4'd9,
    UOP_MACH_FRAME      = 4'd10
  } uop_t;

  typedef enum logic [2:0] {
    KIND_GPR   = 3'd0,
    KIND_XMM   = 3'd1,
    KIND_RIP   = 3'd2,
    KIND_SP    = 3'd3,
    KIND_FINAL = 3'd4
  } kind_t;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_SKIP  = 4'b0010,
    PH_EXEC  = 4'b0100,
    PH_DRAIN = 4'b1000
  } phase_t;

  typedef struct packed {
    logic        op;
    logic [63:0] start_sp;
    logic [63:0] frame_base;
    logic [63:0] frame_reg_value;
    logic [3:0]  frame_scale;
    logic [7:0]  prolog_offset;
    logic [7:0]  slot_count;
    logic [15:0] code_slot;
  } item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  reg_index;
    logic [63:0] address;
    logic        last;
  } res_t;

  // number of slots an operation occupies, opcode slot included
  function automatic logic [1:0] slots_of(logic [3:0] opc, logic [3:0] info);
    logic [1:0] n;
    case (opc)
      UOP_ALLOC_LARGE:     n = (info != 4'd0) ? 2'd3 : 2'd2;
      UOP_SAVE_NONVOL:     n = 2'd2;
      UOP_EPILOG:          n = 2'd2;
      UOP_SAVE_XMM128:     n = 2'd2;
      UOP_SAVE_NONVOL_FAR: n = 2'd3;
      UOP_SPARE:           n = 2'd3;
      UOP_SAVE_XMM128_FAR: n = 2'd3;
      default:             n = 2'd1;
    endcase
    return n;
  endfunction

  function automatic res_t make_res(kind_t k, logic [3:0] r, logic [63:0] a, logic l);
    res_t x;
    x.kind      = k;
    x.reg_index = r;
    x.address   = a;
    x.last      = l;
    return x;
  endfunction

endpackage

[rtl/core/ucint_exec.sv]
// frame state and combinational execution of one begin or slot item
module ucint_exec (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  fire,
  input  ucint_pkg::item_t      item,
  output ucint_pkg::res_t       res [ucint_pkg::RESQ_MAX_PUSH],
  output logic [1:0]            res_count
);

  logic [63:0]       stack_ptr, stack_ptr_next;
  logic [63:0]       base_addr, base_addr_next;
  logic [63:0]       fp_value, fp_value_next;
  logic [3:0]        fp_scale, fp_scale_next;
  logic [7:0]        pc_offset, pc_offset_next;
  logic [7:0]        slots_left, slots_left_next;
  ucint_pkg::phase_t phase, phase_next;
  logic [7:0]        pending_code, pending_code_next;
  logic [1:0]        operand_slots_left, operand_slots_left_next;
  logic [15:0]       operand_low, operand_low_next;

  logic        do_exec;
  logic [3:0]  x_opc;
  logic [3:0]  x_info;
  logic [31:0] x_val;
  logic [1:0]  new_slots;
  logic [4:0]  small_units;

  assign new_slots   = ucint_pkg::slots_of(item.code_slot[11:8], item.code_slot[15:12]);
  assign small_units = {1'b0, x_info} + 5'd1;

  always_comb begin
    stack_ptr_next          = stack_ptr;
    base_addr_next          = base_addr;
    fp_value_next           = fp_value;
    fp_scale_next           = fp_scale;
    pc_offset_next          = pc_offset;
    slots_left_next         = slots_left;
    phase_next              = phase;
    pending_code_next       = pending_code;
    operand_slots_left_next = operand_slots_left;
    operand_low_next        = operand_low;
    for (int i = 0; i < ucint_pkg::RESQ_MAX_PUSH; i++) begin
      res[i] = '0;
    end
    res_count = 2'd0;
    do_exec   = 1'b0;
    x_opc     = pending_code[7:4];
    x_info    = pending_code[3:0];
    x_val     = '0;

    if (item.op == ucint_pkg::ITEM_BEGIN) begin
      stack_ptr_next          = item.start_sp;
      base_addr_next          = item.frame_base;
      fp_value_next           = item.frame_reg_value;
      fp_scale_next           = item.frame_scale;
      pc_offset_next          = item.prolog_offset;
      slots_left_next         = item.slot_count;
      pending_code_next       = '0;
      operand_slots_left_next = '0;
      operand_low_next        = '0;
      phase_next              = ucint_pkg::PH_SKIP;
      if (item.slot_count == 8'd0) begin
        res[0] = ucint_pkg::make_res(ucint_pkg::KIND_RIP, 4'd0, item.start_sp, 1'b0);
        res[1] = ucint_pkg::make_res(ucint_pkg::KIND_FINAL, 4'd0,
                                     item.start_sp + ucint_pkg::RET_ADDR_SIZE, 1'b1);
        res_count  = 2'd2;
        phase_next = ucint_pkg::PH_IDLE;
      end
    end else if (phase == ucint_pkg::PH_IDLE || slots_left == 8'd0) begin
      phase_next = ucint_pkg::PH_IDLE;
    end else begin
      slots_left_next = slots_left - 8'd1;
      if (phase == ucint_pkg::PH_DRAIN) begin
        if (slots_left_next == 8'd0) begin
          phase_next = ucint_pkg::PH_IDLE;
        end
      end else begin
        if (operand_slots_left != 2'd0) begin
          operand_slots_left_next = operand_slots_left - 2'd1;
          if (operand_slots_left_next != 2'd0) begin
            operand_low_next = item.code_slot;
          end else if (phase == ucint_pkg::PH_EXEC) begin
            do_exec = 1'b1;
            if (ucint_pkg::slots_of(pending_code[7:4], pending_code[3:0]) == 2'd3) begin
              x_val = {item.code_slot, operand_low};
            end else begin
              x_val = {16'd0, item.code_slot};
            end
          end
        end else begin
          x_opc             = item.code_slot[11:8];
          x_info            = item.code_slot[15:12];
          pending_code_next = {item.code_slot[11:8], item.code_slot[15:12]};
          // ops past the pc are still prolog that has not run yet
          if (phase == ucint_pkg::PH_SKIP && item.code_slot[7:0] > pc_offset) begin
            operand_slots_left_next = new_slots - 2'd1;
          end else begin
            phase_next = ucint_pkg::PH_EXEC;
            if (new_slots == 2'd1) begin
              do_exec = 1'b1;
            end else begin
              operand_slots_left_next = new_slots - 2'd1;
            end
          end
        end

        if (do_exec) begin
          case (x_opc)
            ucint_pkg::UOP_PUSH_NONVOL: begin
              res[0] = ucint_pkg::make_res(ucint_pkg::KIND_GPR, x_info, stack_ptr, 1'b0);
              res_count      = 2'd1;
              stack_ptr_next = stack_ptr + ucint_pkg::RET_ADDR_SIZE;
            end
            ucint_pkg::UOP_ALLOC_LARGE: begin
              if (x_info != 4'd0) begin
                stack_ptr_next = stack_ptr + {32'd0, x_val};
              end else begin
                stack_ptr_next = stack_ptr + {29'd0, x_val, 3'd0};
              end
            end
            ucint_pkg::UOP_ALLOC_SMALL: begin
              stack_ptr_next = stack_ptr + {56'd0, small_units, 3'd0};
            end
            ucint_pkg::UOP_SET_FPREG: begin
              stack_ptr_next = fp_value - {56'd0, fp_scale, 4'd0};
            end
            ucint_pkg::UOP_SAVE_NONVOL: begin
              res[0] = ucint_pkg::make_res(ucint_pkg::KIND_GPR, x_info,
                                           base_addr + {29'd0, x_val, 3'd0}, 1'b0);
              res_count = 2'd1;
            end
            ucint_pkg::UOP_SAVE_NONVOL_FAR: begin
              res[0] = ucint_pkg::make_res(ucint_pkg::KIND_GPR, x_info,
                                           base_addr + {32'd0, x_val}, 1'b0);
              res_count = 2'd1;
            end
            ucint_pkg::UOP_SAVE_XMM128: begin
              res[0] = ucint_pkg::make_res(ucint_pkg::KIND_XMM, x_info,
                                           base_addr + {28'd0, x_val, 4'd0}, 1'b0);
              res_count = 2'd1;
            end
            ucint_pkg::UOP_SAVE_XMM128_FAR: begin
              res[0] = ucint_pkg::make_res(ucint_pkg::KIND_XMM, x_info,
                                           base_addr + {32'd0, x_val}, 1'b0);
              res_count = 2'd1;
            end
            ucint_pkg::UOP_MACH_FRAME: begin
              stack_ptr_next = stack_ptr + {57'd0, x_info, 3'd0};
              res[0] = ucint_pkg::make_res(ucint_pkg::KIND_RIP, 4'd0, stack_ptr_next, 1'b0);
              res[1] = ucint_pkg::make_res(ucint_pkg::KIND_SP, 4'd0,
                                           stack_ptr_next + ucint_pkg::MFRAME_SP_OFS, 1'b1);
              res_count  = 2'd2;
              phase_next = ucint_pkg::PH_DRAIN;
            end
            default: begin
            end
          endcase
        end

        // out of slots: a machine frame already closed the frame, else close it with rip and final
        if (slots_left_next == 8'd0) begin
          if (phase_next == ucint_pkg::PH_DRAIN) begin
            phase_next = ucint_pkg::PH_IDLE;
          end else begin
            res[res_count] = ucint_pkg::make_res(ucint_pkg::KIND_RIP, 4'd0,
                                                 stack_ptr_next, 1'b0);
            res[res_count + 2'd1] = ucint_pkg::make_res(ucint_pkg::KIND_FINAL, 4'd0,
                                    stack_ptr_next + ucint_pkg::RET_ADDR_SIZE, 1'b1);
            res_count  = res_count + 2'd2;
            phase_next = ucint_pkg::PH_IDLE;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stack_ptr          <= '0;
      base_addr          <= '0;
      fp_value           <= '0;
      fp_scale           <= '0;
      pc_offset          <= '0;
      slots_left         <= '0;
      phase              <= ucint_pkg::PH_IDLE;
      pending_code       <= '0;
      operand_slots_left <= '0;
      operand_low        <= '0;
    end else if (fire) begin
      stack_ptr          <= stack_ptr_next;
      base_addr          <= base_addr_next;
      fp_value           <= fp_value_next;
      fp_scale           <= fp_scale_next;
      pc_offset          <= pc_offset_next;
      slots_left         <= slots_left_next;
      phase              <= phase_next;
      pending_code       <= pending_code_next;
      operand_slots_left <= operand_slots_left_next;
      operand_low        <= operand_low_next;
    end
  end

  // a begin either waits for slots or closes the frame with two requests
  assert property (@(posedge clk) disable iff (rst)
    fire && item.op == ucint_pkg::ITEM_BEGIN |-> res_count == 2'd0 || res_count == 2'd2)
    else $error("begin item gave an odd number of requests");

  // a closing request leaves the frame idle or draining
  assert property (@(posedge clk) disable iff (rst)
    fire && res_count != 2'd0 && res[res_count - 2'd1].last
      |=> phase == ucint_pkg::PH_IDLE || phase == ucint_pkg::PH_DRAIN)
    else $error("frame still active after its last request");

  // slots are only consumed while a frame is open
  assert property (@(posedge clk) disable iff (rst)
    fire && phase == ucint_pkg::PH_IDLE && item.op == ucint_pkg::ITEM_SLOT
      |-> res_count == 2'd0)
    else $error("requests from a slot outside any frame");

endmodule

[rtl/core/ucint_resq.sv]
// result queue: up to three requests written per cycle, one read per cycle
module ucint_resq (
  input  logic              clk,
  input  logic              rst,
  input  logic [1:0]        push_n,
  input  ucint_pkg::res_t   push_data [ucint_pkg::RESQ_MAX_PUSH],
  input  logic              pop,
  output ucint_pkg::res_t   head,
  output logic              not_empty,
  output logic              room
);

  localparam int PW = ucint_pkg::RESQ_PTR_W;
  localparam int CW = ucint_pkg::RESQ_CNT_W;

  ucint_pkg::res_t mem [ucint_pkg::RESQ_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            do_pop;

  assign not_empty = (count != '0);
  assign do_pop    = pop && not_empty;
  assign room      = (count <= CW'(ucint_pkg::RESQ_DEPTH - ucint_pkg::RESQ_MAX_PUSH));
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    for (int i = 0; i < ucint_pkg::RESQ_MAX_PUSH; i++) begin
      if (2'(i) < push_n) begin
        mem[wr_ptr + PW'(i)] <= push_data[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PW'(push_n);
      rd_ptr <= rd_ptr + PW'(do_pop);
      count  <= count + CW'(push_n) - CW'(do_pop);
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    push_n != 2'd0 |-> room)
    else $error("requests written into a queue without room");

  assert property (@(posedge clk) disable iff (rst)
    count <= CW'(ucint_pkg::RESQ_DEPTH))
    else $error("result queue count beyond depth");

endmodule

[rtl/core/unwind_code_interpreter_core.sv]
// top level of the x64 unwind code interpreter
//
//   port group   dir   handshake             payload
//   input item   in    in_valid / in_ready   op, start_sp, frame_base, frame_reg_value,
//                                            frame_scale, prolog_offset, slot_count, code_slot
//   load request out   out_valid / out_ready kind, reg_index, address, last
//
// an accepted item waits in the input register until the result queue has room, is then executed
// combinationally, and its requests are written into the queue, whose head drives the output
// one item per cycle while items give at most one request and the output is not stalled;
// a frame's closing item gives two or three, which leave one per cycle through the single
// read port of the four-entry result queue, and execution waits with fewer than three free
// reset clears the frame state (idle) and empties both the input register and the queue
// a stalled output only holds the input side once the queue holds two or more requests
module unwind_code_interpreter_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        op,
  input  logic [63:0] start_sp,
  input  logic [63:0] frame_base,
  input  logic [63:0] frame_reg_value,
  input  logic [3:0]  frame_scale,
  input  logic [7:0]  prolog_offset,
  input  logic [7:0]  slot_count,
  input  logic [15:0] code_slot,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  kind,
  output logic [3:0]  reg_index,
  output logic [63:0] address,
  output logic        last
);

  logic             item_valid;
  ucint_pkg::item_t item;
  logic             exec_fire;
  logic             q_room;
  ucint_pkg::res_t  exec_res [ucint_pkg::RESQ_MAX_PUSH];
  logic [1:0]       exec_count;
  ucint_pkg::res_t  q_head;

  assign exec_fire = item_valid && q_room;
  assign in_ready  = !item_valid || exec_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.op              <= op;
      item.start_sp        <= start_sp;
      item.frame_base      <= frame_base;
      item.frame_reg_value <= frame_reg_value;
      item.frame_scale     <= frame_scale;
      item.prolog_offset   <= prolog_offset;
      item.slot_count      <= slot_count;
      item.code_slot       <= code_slot;
    end
  end

  ucint_exec u_exec (
    .clk       (clk),
    .rst       (rst),
    .fire      (exec_fire),
    .item      (item),
    .res       (exec_res),
    .res_count (exec_count)
  );

  ucint_resq u_resq (
    .clk       (clk),
    .rst       (rst),
    .push_n    (exec_fire ? exec_count : 2'd0),
    .push_data (exec_res),
    .pop       (out_ready),
    .head      (q_head),
    .not_empty (out_valid),
    .room      (q_room)
  );

  assign kind      = q_head.kind;
  assign reg_index = q_head.reg_index;
  assign address   = q_head.address;
  assign last      = q_head.last;

endmodule
